[src/tofseq_pkg.sv]
`default_nettype none

package tofseq_pkg;

	// sequence phases
	typedef enum logic [3:0] {
		PH_DEFAULTS = 4'd0,
		PH_RUN_ON   = 4'd1,
		PH_ASK_POL  = 4'd2,
		PH_GOT_POL  = 4'd3,
		PH_GOT_STAT = 4'd4,
		PH_HALT     = 4'd5,
		PH_TMO_A    = 4'd6,
		PH_TMO_B    = 4'd7,
		PH_ASK_ID   = 4'd8,
		PH_GOT_ID   = 4'd9,
		PH_DIST     = 4'd10
	} phase_t;

	// bus command codes
	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_READ  = 2'd2
	} kind_t;

	// input opcodes
	localparam logic OP_START = 1'b0;
	localparam logic OP_DONE  = 1'b1;

	// default block range
	localparam logic [7:0] FIRST_DEFAULT = 8'h2D;
	localparam logic [7:0] LAST_DEFAULT  = 8'h87;

	// sensor registers and values
	localparam logic [15:0] ADDR_INT_CLEAR = 16'h0086;
	localparam logic [15:0] ADDR_MODE      = 16'h0087;
	localparam logic [15:0] ADDR_POLARITY  = 16'h0030;
	localparam logic [15:0] ADDR_STATUS    = 16'h0031;
	localparam logic [15:0] ADDR_TMO_A     = 16'h0008;
	localparam logic [15:0] ADDR_TMO_B     = 16'h000B;
	localparam logic [15:0] ADDR_MODEL_ID  = 16'h010F;
	localparam logic [15:0] ADDR_DISTANCE  = 16'h0096;
	localparam logic [7:0]  VAL_INT_CLEAR  = 8'h01;
	localparam logic [7:0]  VAL_RANGE_ON   = 8'h40;
	localparam logic [7:0]  VAL_RANGE_OFF  = 8'h00;
	localparam logic [7:0]  VAL_TMO_A      = 8'h09;
	localparam logic [7:0]  VAL_TMO_B      = 8'h00;

	typedef struct packed {
		logic       opcode;
		logic [7:0] rx_first_byte;
		logic [7:0] rx_second_byte;
		logic       engine_refuses;
	} item_t;

	typedef struct packed {
		logic [1:0]  command_kind;
		logic [15:0] register_address;
		logic [7:0]  write_value;
		logic [1:0]  read_count;
		logic        distance_valid;
		logic [15:0] distance_mm;
		logic        command_error;
	} res_t;

	// default register contents, entries not listed are zero
	function automatic logic [7:0] default_rom(input logic [6:0] idx);
		logic [7:0] v;
		case (idx)
			7'd1, 7'd2, 7'd3, 7'd11, 7'd12, 7'd44, 7'd49, 7'd52, 7'd55, 7'd74,
			7'd88: v = 8'h01;
			7'd4, 7'd6, 7'd29, 7'd81: v = 8'h02;
			7'd7, 7'd9, 7'd46, 7'd59: v = 8'h08;
			7'd10: v = 8'h10;
			7'd17, 7'd43, 7'd83: v = 8'hff;
			7'd19, 7'd51, 7'd65, 7'd75: v = 8'h0f;
			7'd25: v = 8'h20;
			7'd26: v = 8'h0b;
			7'd30: v = 8'h0a;
			7'd31: v = 8'h21;
			7'd34: v = 8'h05;
			7'd39: v = 8'hc8;
			7'd42: v = 8'h38;
			7'd50: v = 8'hdb;
			7'd53: v = 8'hf1;
			7'd54, 7'd76: v = 8'h0d;
			7'd56: v = 8'h68;
			7'd58: v = 8'h80;
			7'd60: v = 8'hb8;
			7'd66: v = 8'h89;
			7'd77, 7'd78: v = 8'h0e;
			7'd82: v = 8'hc7;
			7'd84: v = 8'h9b;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

[src/tofseq_in_if.sv]
`default_nettype none

interface tofseq_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] rx_first_byte;
	logic [7:0] rx_second_byte;
	logic       engine_refuses;

	modport source (output valid, opcode, rx_first_byte, rx_second_byte, engine_refuses,
		input ready);
	modport sink (input valid, opcode, rx_first_byte, rx_second_byte, engine_refuses,
		output ready);
endinterface

`default_nettype wire

[src/tofseq_out_if.sv]
`default_nettype none

interface tofseq_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command_kind;
	logic [15:0] register_address;
	logic [7:0]  write_value;
	logic [1:0]  read_count;
	logic        distance_valid;
	logic [15:0] distance_mm;
	logic        command_error;

	modport source (output valid, command_kind, register_address, write_value, read_count,
		distance_valid, distance_mm, command_error, input ready);
	modport sink (input valid, command_kind, register_address, write_value, read_count,
		distance_valid, distance_mm, command_error, output ready);
endinterface

`default_nettype wire

[src/tof_sensor_init_and_range_sequencer.sv]
// Bring-up sequencer for a ranging sensor. Each input beat is a start (rewind and
// issue the first command) or a transfer-done notice carrying the bytes of the last
// read; each one yields exactly one result beat holding the next bus command, a
// refusal flag, or in the final phase the assembled distance. One beat is taken per
// clock cycle unless the result side stalls; a beat passes an input register, one step
// of sequencer logic (phase decode, default-value ROM lookup and state update) and a
// result register, which holds its result until the result side takes it.
`default_nettype none

module tof_sensor_init_and_range_sequencer (
	input wire           clk,
	input wire           arst_n,
	tofseq_in_if.sink    item,
	tofseq_out_if.source result
);

	logic               vld_s1;
	tofseq_pkg::item_t  item_s1;
	logic               vld_s2;
	tofseq_pkg::res_t   res_s2;
	tofseq_pkg::res_t   res_d;
	logic               adv;
	logic               take;

	assign adv       = vld_s1 && (!vld_s2 || result.ready);
	assign item.ready = !vld_s1 || adv;
	assign take      = item.valid && item.ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item.ready) begin
			vld_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= '{opcode: item.opcode, rx_first_byte: item.rx_first_byte,
				rx_second_byte: item.rx_second_byte, engine_refuses: item.engine_refuses};
		end
	end

	tofseq_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.item   (item_s1),
		.res    (res_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (!vld_s2 || result.ready) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_d;
		end
	end

	assign result.valid            = vld_s2;
	assign result.command_kind     = res_s2.command_kind;
	assign result.register_address = res_s2.register_address;
	assign result.write_value      = res_s2.write_value;
	assign result.read_count       = res_s2.read_count;
	assign result.distance_valid   = res_s2.distance_valid;
	assign result.distance_mm      = res_s2.distance_mm;
	assign result.command_error    = res_s2.command_error;

	// a refused beat carries no command
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.command_error |->
			result.command_kind == 2'(tofseq_pkg::KIND_NONE) && !result.distance_valid)
		else $error("refused beat carries a command");

	// read count is set exactly for reads
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |->
			((result.command_kind == 2'(tofseq_pkg::KIND_READ)) == (result.read_count != 2'd0)))
		else $error("read count does not match command kind");

	// distance reports come with no command
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.distance_valid |->
			result.command_kind == 2'(tofseq_pkg::KIND_NONE))
		else $error("distance beat carries a command");

	// a stalled stage one beat is not lost
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !adv |=> vld_s1)
		else $error("stalled beat dropped");

endmodule

`default_nettype wire

[src/tofseq_step.sv]
`default_nettype none

module tofseq_step (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                en,
	input  wire tofseq_pkg::item_t item,
	output tofseq_pkg::res_t   res
);

	tofseq_pkg::phase_t phase_q, phase_d, phase_cur;
	logic [7:0]         ndr_q, ndr_d, ndr_cur;
	logic               pol_q, pol_d;
	logic               issued;
	logic               has_cmd;
	logic               status_ready;
	tofseq_pkg::kind_t  kind;
	logic [15:0]        addr;
	logic [7:0]         wval;
	logic [1:0]         rcnt;
	logic [6:0]         rom_idx;

	// a start beat rewinds before the phase is looked at
	always_comb begin
		if (item.opcode == tofseq_pkg::OP_START) begin
			phase_cur = tofseq_pkg::PH_DEFAULTS;
			ndr_cur   = tofseq_pkg::FIRST_DEFAULT;
		end else begin
			phase_cur = phase_q;
			ndr_cur   = ndr_q;
		end
	end

	assign rom_idx      = 7'(ndr_cur - tofseq_pkg::FIRST_DEFAULT);
	assign status_ready = (item.rx_first_byte[0] == pol_q);
	assign issued       = !item.engine_refuses;

	// command for the current phase
	always_comb begin
		has_cmd = 1'b1;
		kind    = tofseq_pkg::KIND_NONE;
		addr    = '0;
		wval    = '0;
		rcnt    = '0;
		case (phase_cur)
			tofseq_pkg::PH_DEFAULTS: begin
				kind = tofseq_pkg::KIND_WRITE;
				if (ndr_cur > tofseq_pkg::LAST_DEFAULT) begin
					addr = tofseq_pkg::ADDR_INT_CLEAR;
					wval = tofseq_pkg::VAL_INT_CLEAR;
				end else begin
					addr = {8'h00, ndr_cur};
					wval = tofseq_pkg::default_rom(rom_idx);
				end
			end
			tofseq_pkg::PH_RUN_ON: begin
				kind = tofseq_pkg::KIND_WRITE;
				addr = tofseq_pkg::ADDR_MODE;
				wval = tofseq_pkg::VAL_RANGE_ON;
			end
			tofseq_pkg::PH_ASK_POL: begin
				kind = tofseq_pkg::KIND_READ;
				addr = tofseq_pkg::ADDR_POLARITY;
				rcnt = 2'd1;
			end
			tofseq_pkg::PH_GOT_POL: begin
				kind = tofseq_pkg::KIND_READ;
				addr = tofseq_pkg::ADDR_STATUS;
				rcnt = 2'd1;
			end
			tofseq_pkg::PH_GOT_STAT: begin
				if (status_ready) begin
					kind = tofseq_pkg::KIND_WRITE;
					addr = tofseq_pkg::ADDR_INT_CLEAR;
					wval = tofseq_pkg::VAL_INT_CLEAR;
				end else begin
					kind = tofseq_pkg::KIND_READ;
					addr = tofseq_pkg::ADDR_POLARITY;
					rcnt = 2'd1;
				end
			end
			tofseq_pkg::PH_HALT: begin
				kind = tofseq_pkg::KIND_WRITE;
				addr = tofseq_pkg::ADDR_MODE;
				wval = tofseq_pkg::VAL_RANGE_OFF;
			end
			tofseq_pkg::PH_TMO_A: begin
				kind = tofseq_pkg::KIND_WRITE;
				addr = tofseq_pkg::ADDR_TMO_A;
				wval = tofseq_pkg::VAL_TMO_A;
			end
			tofseq_pkg::PH_TMO_B: begin
				kind = tofseq_pkg::KIND_WRITE;
				addr = tofseq_pkg::ADDR_TMO_B;
				wval = tofseq_pkg::VAL_TMO_B;
			end
			tofseq_pkg::PH_ASK_ID: begin
				kind = tofseq_pkg::KIND_READ;
				addr = tofseq_pkg::ADDR_MODEL_ID;
				rcnt = 2'd2;
			end
			tofseq_pkg::PH_GOT_ID: begin
				kind = tofseq_pkg::KIND_READ;
				addr = tofseq_pkg::ADDR_DISTANCE;
				rcnt = 2'd2;
			end
			default: has_cmd = 1'b0;
		endcase
	end

	// result beat: issued command, refused command or distance report
	always_comb begin
		res = '0;
		if (phase_cur == tofseq_pkg::PH_DIST) begin
			res.distance_valid = 1'b1;
			res.distance_mm    = {item.rx_first_byte, item.rx_second_byte};
		end else if (has_cmd) begin
			if (issued) begin
				res.command_kind     = 2'(kind);
				res.register_address = addr;
				res.write_value      = wval;
				res.read_count       = rcnt;
			end else begin
				res.command_error = 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		phase_d = phase_cur;
		ndr_d   = ndr_cur;
		pol_d   = pol_q;
		if (phase_cur == tofseq_pkg::PH_GOT_POL) begin
			pol_d = !item.rx_first_byte[4];
		end
		if (issued) begin
			case (phase_cur)
				tofseq_pkg::PH_DEFAULTS: begin
					if (ndr_cur > tofseq_pkg::LAST_DEFAULT) begin
						phase_d = tofseq_pkg::PH_RUN_ON;
					end else begin
						ndr_d = ndr_cur + 8'd1;
					end
				end
				tofseq_pkg::PH_RUN_ON:   phase_d = tofseq_pkg::PH_ASK_POL;
				tofseq_pkg::PH_ASK_POL:  phase_d = tofseq_pkg::PH_GOT_POL;
				tofseq_pkg::PH_GOT_POL:  phase_d = tofseq_pkg::PH_GOT_STAT;
				tofseq_pkg::PH_GOT_STAT: begin
					phase_d = status_ready ? tofseq_pkg::PH_HALT : tofseq_pkg::PH_GOT_POL;
				end
				tofseq_pkg::PH_HALT:     phase_d = tofseq_pkg::PH_TMO_A;
				tofseq_pkg::PH_TMO_A:    phase_d = tofseq_pkg::PH_TMO_B;
				tofseq_pkg::PH_TMO_B:    phase_d = tofseq_pkg::PH_ASK_ID;
				tofseq_pkg::PH_ASK_ID:   phase_d = tofseq_pkg::PH_GOT_ID;
				tofseq_pkg::PH_GOT_ID:   phase_d = tofseq_pkg::PH_DIST;
				default:                 phase_d = phase_cur;
			endcase
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tofseq_pkg::PH_DEFAULTS;
			ndr_q   <= tofseq_pkg::FIRST_DEFAULT;
			pol_q   <= 1'b0;
		end else if (en) begin
			phase_q <= phase_d;
			ndr_q   <= ndr_d;
			pol_q   <= pol_d;
		end
	end

endmodule

`default_nettype wire

[verif/tb_tof_sensor_init_and_range_sequencer.sv]
`timescale 1ns / 100ps

module tb_tof_sensor_init_and_range_sequencer;
	import tofseq_pkg::*;

	localparam int TOTAL_BEATS = 1600;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		item_t stim;
		bit    typed;
		res_t  want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tofseq_in_if  item_bus ();
	tofseq_out_if cmd_bus ();

	tof_sensor_init_and_range_sequencer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (cmd_bus)
	);

	// clock, 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// default register contents written during bring-up, from 0x2d upwards
	logic [7:0] init_bytes [0:90] = '{
		8'h00, 8'h01, 8'h01, 8'h01, 8'h02, 8'h00, 8'h02, 8'h08, 8'h00, 8'h08, 8'h10, 8'h01,
		8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'h00, 8'h0f, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h20, 8'h0b, 8'h00, 8'h00, 8'h02, 8'h0a, 8'h21, 8'h00, 8'h00, 8'h05, 8'h00,
		8'h00, 8'h00, 8'h00, 8'hc8, 8'h00, 8'h00, 8'h38, 8'hff, 8'h01, 8'h00, 8'h08, 8'h00,
		8'h00, 8'h01, 8'hdb, 8'h0f, 8'h01, 8'hf1, 8'h0d, 8'h01, 8'h68, 8'h00, 8'h80, 8'h08,
		8'hb8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0f, 8'h89, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h01, 8'h0f, 8'h0d, 8'h0e, 8'h0e, 8'h00, 8'h00, 8'h02, 8'hc7, 8'hff,
		8'h9b, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00
	};

	// mirror of the sequencer state
	phase_t     seq_phase = PH_DEFAULTS;
	logic [7:0] seq_next_reg = FIRST_DEFAULT;
	logic       seq_polarity = 1'b0;

	res_t pending_cmds [$];
	int   fault_count = 0;
	int   beats_sent = 0;
	int   beats_seen = 0;
	int   src_idle_pct = 21;
	int   snk_idle_pct = 76;

	function automatic res_t bus_cmd(input kind_t kind, input logic [15:0] addr,
		input logic [7:0] value, input logic [1:0] count);
		res_t r;
		r = '0;
		r.command_kind = kind;
		r.register_address = addr;
		r.write_value = value;
		r.read_count = count;
		return r;
	endfunction

	function automatic res_t refusal();
		res_t r;
		r = '0;
		r.command_error = 1'b1;
		return r;
	endfunction

	// next bus command of the bring-up sequence, advancing the mirrored state
	function automatic res_t next_bus_cmd(input item_t it);
		res_t   r;
		phase_t nxt;
		logic   issues;
		logic   bump;
		r = '0;
		issues = 1'b1;
		bump = 1'b0;
		if (it.opcode == OP_START) begin
			seq_phase = PH_DEFAULTS;
			seq_next_reg = FIRST_DEFAULT;
		end
		nxt = seq_phase;
		case (seq_phase)
			PH_DEFAULTS: begin
				if (seq_next_reg > LAST_DEFAULT) begin
					r = bus_cmd(KIND_WRITE, ADDR_INT_CLEAR, VAL_INT_CLEAR, 2'd0);
					nxt = PH_RUN_ON;
				end else begin
					r = bus_cmd(KIND_WRITE, {8'h00, seq_next_reg},
						init_bytes[seq_next_reg - FIRST_DEFAULT], 2'd0);
					bump = 1'b1;
				end
			end
			PH_RUN_ON: begin
				r = bus_cmd(KIND_WRITE, ADDR_MODE, VAL_RANGE_ON, 2'd0);
				nxt = PH_ASK_POL;
			end
			PH_ASK_POL: begin
				r = bus_cmd(KIND_READ, ADDR_POLARITY, 8'h00, 2'd1);
				nxt = PH_GOT_POL;
			end
			PH_GOT_POL: begin
				// polarity is taken even when the follow-up read is refused
				seq_polarity = ~it.rx_first_byte[4];
				r = bus_cmd(KIND_READ, ADDR_STATUS, 8'h00, 2'd1);
				nxt = PH_GOT_STAT;
			end
			PH_GOT_STAT: begin
				if (it.rx_first_byte[0] == seq_polarity) begin
					r = bus_cmd(KIND_WRITE, ADDR_INT_CLEAR, VAL_INT_CLEAR, 2'd0);
					nxt = PH_HALT;
				end else begin
					r = bus_cmd(KIND_READ, ADDR_POLARITY, 8'h00, 2'd1);
					nxt = PH_GOT_POL;
				end
			end
			PH_HALT: begin
				r = bus_cmd(KIND_WRITE, ADDR_MODE, VAL_RANGE_OFF, 2'd0);
				nxt = PH_TMO_A;
			end
			PH_TMO_A: begin
				r = bus_cmd(KIND_WRITE, ADDR_TMO_A, VAL_TMO_A, 2'd0);
				nxt = PH_TMO_B;
			end
			PH_TMO_B: begin
				r = bus_cmd(KIND_WRITE, ADDR_TMO_B, VAL_TMO_B, 2'd0);
				nxt = PH_ASK_ID;
			end
			PH_ASK_ID: begin
				r = bus_cmd(KIND_READ, ADDR_MODEL_ID, 8'h00, 2'd2);
				nxt = PH_GOT_ID;
			end
			PH_GOT_ID: begin
				r = bus_cmd(KIND_READ, ADDR_DISTANCE, 8'h00, 2'd2);
				nxt = PH_DIST;
			end
			PH_DIST: begin
				// distance report, refusal flag has no effect here
				issues = 1'b0;
				r.distance_valid = 1'b1;
				r.distance_mm = {it.rx_first_byte, it.rx_second_byte};
			end
			default: begin
				issues = 1'b0;
			end
		endcase
		if (issues && it.engine_refuses) begin
			r = refusal();
		end else begin
			seq_phase = nxt;
			if (bump)
				seq_next_reg = seq_next_reg + 8'd1;
		end
		return r;
	endfunction

	task automatic report(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		fault_count++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
		input logic [15:0] want);
		if (got !== want)
			report($sformatf("result beat %0d %s got 0x%0h expected 0x%0h",
				beats_seen, name, got, want));
	endtask

	// one input beat; the expectation is queued on acceptance
	task automatic send_beat(input item_t it, input bit typed, input res_t want);
		res_t predicted;
		// idling regime follows the share of beats already sent
		if (beats_sent >= 2 * TOTAL_BEATS / 3) begin
			src_idle_pct = 0;
			snk_idle_pct = 0;
		end else if (beats_sent >= TOTAL_BEATS / 3) begin
			src_idle_pct = 76;
			snk_idle_pct = 21;
		end
		while ($urandom_range(99) < src_idle_pct) begin
			item_bus.valid <= 1'b0;
			@(negedge clk);
		end
		item_bus.valid <= 1'b1;
		item_bus.opcode <= it.opcode;
		item_bus.rx_first_byte <= it.rx_first_byte;
		item_bus.rx_second_byte <= it.rx_second_byte;
		item_bus.engine_refuses <= it.engine_refuses;
		do
			@(posedge clk);
		while (!item_bus.ready);
		predicted = next_bus_cmd(it);
		pending_cmds.push_back(typed ? want : predicted);
		beats_sent++;
		@(negedge clk);
	endtask

	// well-formed bring-up run with random content, odd rewinds and refusals
	task automatic random_run();
		item_t it;
		int    dist_left;
		it.opcode = OP_START;
		it.rx_first_byte = 8'($urandom);
		it.rx_second_byte = 8'($urandom);
		it.engine_refuses = ($urandom_range(7) == 0);
		send_beat(it, 1'b0, '0);
		dist_left = $urandom_range(4, 1);
		while (dist_left > 0 && beats_sent < TOTAL_BEATS) begin
			it.opcode = ($urandom_range(199) == 0) ? OP_START : OP_DONE;
			it.rx_first_byte = 8'($urandom);
			it.rx_second_byte = 8'($urandom);
			it.engine_refuses = ($urandom_range(7) == 0);
			// bias the status byte towards data ready so runs get through
			if (seq_phase == PH_GOT_STAT && $urandom_range(9) < 6)
				it.rx_first_byte[0] = seq_polarity;
			if (seq_phase == PH_DIST && it.opcode == OP_DONE)
				dist_left--;
			send_beat(it, 1'b0, '0);
		end
	endtask

	// result side: random stalls, compare against oldest expectation
	initial begin
		cmd_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			cmd_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && cmd_bus.valid && cmd_bus.ready) begin
			if (pending_cmds.size() == 0) begin
				report($sformatf("result beat %0d arrived with nothing expected", beats_seen));
			end else begin
				want = pending_cmds.pop_front();
				check_field("command_kind", 16'(cmd_bus.command_kind), 16'(want.command_kind));
				check_field("register_address", cmd_bus.register_address,
					want.register_address);
				check_field("write_value", 16'(cmd_bus.write_value), 16'(want.write_value));
				check_field("read_count", 16'(cmd_bus.read_count), 16'(want.read_count));
				check_field("distance_valid", 16'(cmd_bus.distance_valid),
					16'(want.distance_valid));
				check_field("distance_mm", cmd_bus.distance_mm, want.distance_mm);
				check_field("command_error", 16'(cmd_bus.command_error),
					16'(want.command_error));
			end
			beats_seen++;
		end
	end

	// run limit
	initial begin
		#5_000_000;
		$display("** tof_sensor_init_and_range_sequencer: FAILED **");
		$finish;
	end

	// stimulus
	initial begin
		plan_row_t plan [11];
		item_bus.valid = 1'b0;
		item_bus.opcode = OP_START;
		item_bus.rx_first_byte = 8'h00;
		item_bus.rx_second_byte = 8'h00;
		item_bus.engine_refuses = 1'b0;

		// directed beats: after reset, refusals, rewinds, byte extremes
		plan[0] = '{'{OP_DONE, 8'hff, 8'hff, 1'b0}, 1'b1,
			bus_cmd(KIND_WRITE, 16'h002d, 8'h00, 2'd0)};
		plan[1] = '{'{OP_DONE, 8'h00, 8'h00, 1'b1}, 1'b1, refusal()};
		plan[2] = '{'{OP_DONE, 8'h00, 8'hff, 1'b0}, 1'b1,
			bus_cmd(KIND_WRITE, 16'h002e, 8'h01, 2'd0)};
		plan[3] = '{'{OP_DONE, 8'ha5, 8'h5a, 1'b0}, 1'b0, '0};
		plan[4] = '{'{OP_START, 8'h00, 8'h00, 1'b1}, 1'b1, refusal()};
		plan[5] = '{'{OP_START, 8'hff, 8'h00, 1'b0}, 1'b1,
			bus_cmd(KIND_WRITE, 16'h002d, 8'h00, 2'd0)};
		plan[6] = '{'{OP_DONE, 8'h12, 8'h34, 1'b1}, 1'b1, refusal()};
		plan[7] = '{'{OP_DONE, 8'h00, 8'h00, 1'b0}, 1'b1,
			bus_cmd(KIND_WRITE, 16'h002e, 8'h01, 2'd0)};
		plan[8] = '{'{OP_DONE, 8'h80, 8'h01, 1'b0}, 1'b0, '0};
		plan[9] = '{'{OP_START, 8'h0f, 8'hf0, 1'b0}, 1'b1,
			bus_cmd(KIND_WRITE, 16'h002d, 8'h00, 2'd0)};
		plan[10] = '{'{OP_DONE, 8'hff, 8'hff, 1'b1}, 1'b1, refusal()};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i])
			send_beat(plan[i].stim, plan[i].typed, plan[i].want);

		// random runs in three idling regimes
		while (beats_sent < TOTAL_BEATS)
			random_run();
		item_bus.valid <= 1'b0;

		// drain
		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fault_count == 0)
			$display("** tof_sensor_init_and_range_sequencer: PASSED **");
		else
			$display("** tof_sensor_init_and_range_sequencer: FAILED **");
		$finish;
	end

endmodule

[sim.f]
src/tofseq_pkg.sv
src/tofseq_in_if.sv
src/tofseq_out_if.sv
src/tofseq_step.sv
src/tof_sensor_init_and_range_sequencer.sv
verif/tb_tof_sensor_init_and_range_sequencer.sv
